// ===== hw/rtl/binary_trie_key_counter_macros.svh =====
// Assertion macros shared by the trie key counter RTL.
// No dependencies; clock and reset are taken from the including module.
`ifndef BINARY_TRIE_KEY_COUNTER_MACROS_SVH
`define BINARY_TRIE_KEY_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BTKC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BTKC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/btkc_pkg.sv =====
// Package for the trie key counter: sizes, codes, node word layout and
// the command and status structs between controller and datapath. No dependencies.
package btkc_pkg;

   localparam int NODE_COUNT = 65536;
   localparam int KEY_BITS   = 32;
   localparam int KEY_W      = 32;
   localparam int COUNT_W    = 32;
   localparam int TYPE_W     = 2;

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int SLOT_W  = NODE_W + 1;
   localparam int FREE_W  = $clog2(NODE_COUNT + 1);
   localparam int CHK_W   = FREE_W + 1;
   localparam int LEVEL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int MISS_W  = LEVEL_W + 1;

   typedef enum logic [TYPE_W-1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_LOOKUP = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_ALLOC,
      ST_CNT_RD,
      ST_CNT_UPD,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_ZERO,
      RES_ONE,
      RES_FULL,
      RES_RAW,
      RES_INC
   } res_sel_type;

   // Both links of one node in a single memory word
   typedef struct packed {
      logic              v1;
      logic [NODE_W-1:0] c1;
      logic              v0;
      logic [NODE_W-1:0] c0;
   } node_word_type;

   typedef struct packed {
      logic               ready;
      logic               capture;
      logic               clear_trie;
      logic               step;
      logic               hold_word;
      logic               alloc;
      logic               set_slot;
      logic               cnt_write;
      res_sel_type        res_sel;
      logic               load_rsp;
      logic [LEVEL_W-1:0] level;
   } cmd_type;

   typedef struct packed {
      logic         req_valid;
      req_kind_type new_op;
      req_kind_type op;
      logic         link_ok;
      logic         pool_full;
      logic         rsp_free;
   } sts_type;

endpackage

// ===== hw/rtl/btkc_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
// Depends on btkc_pkg for the field widths.
interface btkc_req_if import btkc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [KEY_W-1:0]  key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface btkc_rsp_if import btkc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] count;
   logic               status;

   modport source (output valid, output count, output status, input ready);
   modport sink   (input valid, input count, input status, output ready);
endinterface

// ===== hw/rtl/btkc_datapath.sv =====
// Datapath of the trie key counter: node and count memories, walk registers,
// bump allocator and response register. Depends on btkc_pkg and btkc_if.
module btkc_datapath import btkc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   btkc_req_if.sink          req,
   btkc_rsp_if.source        rsp
);

   // Memories: one word per node, one count per link slot
   node_word_type      node_mem [NODE_COUNT];
   logic [COUNT_W-1:0] cnt_mem  [2*NODE_COUNT];

   logic [KEY_W-1:0]   key_ff;
   req_kind_type       op_ff;
   logic [NODE_W-1:0]  node_ff;
   node_word_type      word_ff;
   logic [FREE_W-1:0]  free_ff;
   logic [1:0]         root_valid_ff;
   logic [SLOT_W-1:0]  slot_ff;
   node_word_type      node_rdata_ff;
   logic [COUNT_W-1:0] cnt_rdata_ff;
   logic [COUNT_W-1:0] res_count_ff;
   logic               res_status_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_status_ff;

   logic [KEY_W-1:0]   key_shift;
   logic               key_bit;
   logic               cur_valid;
   logic [NODE_W-1:0]  child;
   logic [NODE_W-1:0]  fresh;
   logic [MISS_W-1:0]  missing;
   logic [CHK_W-1:0]   need;
   logic [NODE_W-1:0]  node_raddr;
   node_word_type      alloc_word;
   logic [SLOT_W-1:0]  cnt_waddr;
   logic [COUNT_W-1:0] cnt_wdata;
   logic [COUNT_W-1:0] cnt_inc;
   logic               rsp_free;

   // Key bit of the current level; bits past the key width read as zero
   assign key_shift = key_ff >> cmd.level;
   assign key_bit   = key_shift[0];

   // Link taken at this level; root validity lives in flip-flops
   assign child     = key_bit ? node_rdata_ff.c1 : node_rdata_ff.c0;
   assign cur_valid = (node_ff == '0) ? root_valid_ff[key_bit]
                    : (key_bit ? node_rdata_ff.v1 : node_rdata_ff.v0);
   assign fresh     = free_ff[NODE_W-1:0];

   // Pool check: nodes still to create on this path against what is left
   assign missing = MISS_W'(KEY_BITS) - MISS_W'(cmd.level);
   assign need    = CHK_W'(free_ff) + CHK_W'(missing);

   // Saturating increment of the stored count
   assign cnt_inc = (cnt_rdata_ff == {COUNT_W{1'b1}}) ? cnt_rdata_ff
                  : cnt_rdata_ff + COUNT_W'(1);

   // New word for the node being extended
   always_comb begin
      alloc_word = word_ff;
      if (key_bit) begin
         alloc_word.v1 = 1'b1;
         alloc_word.c1 = fresh;
      end else begin
         alloc_word.v0 = 1'b1;
         alloc_word.c0 = fresh;
      end
   end

   // Node read address: root on capture, child on a step, else current node
   always_comb begin
      priority if (cmd.capture) begin
         node_raddr = '0;
      end else if (cmd.step) begin
         node_raddr = child;
      end else begin
         node_raddr = node_ff;
      end
   end

   assign cnt_waddr = cmd.alloc ? {node_ff, key_bit} : slot_ff;
   assign cnt_wdata = cmd.alloc ? COUNT_W'(1) : cnt_inc;

   // Node memory
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         node_mem[node_ff] <= alloc_word;
      end
      node_rdata_ff <= node_mem[node_raddr];
   end

   // Count memory
   always_ff @(posedge clock) begin
      if (cmd.cnt_write) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[slot_ff];
   end

   // Trie control state: root links and bump pointer
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_trie) begin
         root_valid_ff <= '0;
         free_ff       <= FREE_W'(1);
      end else if (cmd.alloc) begin
         free_ff <= free_ff + FREE_W'(1);
         if (node_ff == '0) begin
            root_valid_ff[key_bit] <= 1'b1;
         end
      end
   end

   // Walk registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff  <= req.key;
         op_ff   <= req_kind_type'(req.req_type);
         node_ff <= '0;
      end else if (cmd.step) begin
         node_ff <= child;
      end else if (cmd.alloc) begin
         node_ff <= fresh;
      end
      if (cmd.hold_word) begin
         word_ff <= node_rdata_ff;
      end else if (cmd.alloc) begin
         word_ff <= '0;
      end
      if (cmd.set_slot) begin
         slot_ff <= {node_ff, key_bit};
      end
   end

   // Result of the current request
   always_ff @(posedge clock) begin
      unique case (cmd.res_sel)
         RES_HOLD: begin
         end
         RES_ZERO: begin
            res_count_ff  <= '0;
            res_status_ff <= 1'b0;
         end
         RES_ONE: begin
            res_count_ff  <= COUNT_W'(1);
            res_status_ff <= 1'b0;
         end
         RES_FULL: begin
            res_count_ff  <= '0;
            res_status_ff <= 1'b1;
         end
         RES_RAW: begin
            res_count_ff  <= cnt_rdata_ff;
            res_status_ff <= 1'b0;
         end
         RES_INC: begin
            res_count_ff  <= cnt_inc;
            res_status_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Response register
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_count_ff  <= res_count_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.count  = rsp_count_ff;
   assign rsp.status = rsp_status_ff;
   assign req.ready  = cmd.ready;

   assign sts.req_valid = req.valid;
   assign sts.new_op    = req_kind_type'(req.req_type);
   assign sts.op        = op_ff;
   assign sts.link_ok   = cur_valid;
   assign sts.pool_full = need > CHK_W'(NODE_COUNT);
   assign sts.rsp_free  = rsp_free;

endmodule

// ===== hw/rtl/btkc_ctrl.sv =====
// Controller of the trie key counter: request sequencing and level counter.
// Depends on btkc_pkg and binary_trie_key_counter_macros.svh.
`include "binary_trie_key_counter_macros.svh"

module btkc_ctrl import btkc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [LEVEL_W-1:0] LastLevel = LEVEL_W'(KEY_BITS - 1);

   state_type          state_ff, state_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               last;

   assign last = (level_ff == LastLevel);

   // State and level registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

   // Next state and commands
   always_comb begin
      cmd         = '0;
      cmd.res_sel = RES_HOLD;
      cmd.level   = level_ff;
      state_in    = state_ff;
      level_in    = level_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (sts.req_valid) begin
               cmd.capture = 1'b1;
               level_in    = '0;
               unique case (sts.new_op)
                  REQ_CLEAR: begin
                     cmd.clear_trie = 1'b1;
                     cmd.res_sel    = RES_ZERO;
                     state_in       = ST_DONE;
                  end
                  REQ_INSERT, REQ_LOOKUP: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                     cmd.res_sel = RES_ZERO;
                     state_in    = ST_DONE;
                  end
               endcase
            end
         end
         // One level per cycle while the path exists
         ST_WALK: begin
            if (sts.link_ok) begin
               if (last) begin
                  cmd.set_slot = 1'b1;
                  state_in     = ST_CNT_RD;
               end else begin
                  cmd.step = 1'b1;
                  level_in = level_ff + LEVEL_W'(1);
               end
            end else if (sts.op == REQ_INSERT) begin
               if (sts.pool_full) begin
                  cmd.res_sel = RES_FULL;
                  state_in    = ST_DONE;
               end else begin
                  cmd.hold_word = 1'b1;
                  state_in      = ST_ALLOC;
               end
            end else begin
               cmd.res_sel = RES_ZERO;
               state_in    = ST_DONE;
            end
         end
         // One new node per cycle down to the end of the key
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            if (last) begin
               cmd.cnt_write = 1'b1;
               cmd.res_sel   = RES_ONE;
               state_in      = ST_DONE;
            end else begin
               level_in = level_ff + LEVEL_W'(1);
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_UPD;
         end
         ST_CNT_UPD: begin
            if (sts.op == REQ_INSERT) begin
               cmd.cnt_write = 1'b1;
               cmd.res_sel   = RES_INC;
            end else begin
               cmd.res_sel = RES_RAW;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Assertions
   `BTKC_ASSERT_NEXT(a_walk_starts_at_root,
      cmd.capture && (sts.new_op == REQ_INSERT || sts.new_op == REQ_LOOKUP),
      state_ff == ST_WALK && level_ff == '0, "walk did not start at level zero")
   `BTKC_ASSERT_IMP(a_load_into_free_slot, cmd.load_rsp, sts.rsp_free,
      "response loaded over an untaken transfer")
   `BTKC_ASSERT_NEXT(a_alloc_advances, state_ff == ST_ALLOC && !last,
      state_ff == ST_ALLOC && level_ff == $past(level_ff) + LEVEL_W'(1),
      "allocation run broke off before the last level")
   `BTKC_ASSERT_IMP(a_count_write_insert_only, cmd.cnt_write, sts.op == REQ_INSERT,
      "count written outside an insert")

endmodule

// ===== hw/rtl/binary_trie_key_counter.sv =====
// Binary trie key counter: counts occurrences of 32-bit keys.
// Request channel req: req_type (clear, insert, look up) and key, valid/ready.
// Response channel rsp: count and status (1 = insert refused, pool full).
// One response per request, in request order.
// Path from request transfer to response valid:
//   clear or unused type: straight to the response register;
//   lookup of an absent key or refused insert: walk up to the first missing link;
//   insert or lookup of a present key: walk of all 32 levels, then count access;
//   insert creating nodes: walk of the existing levels, then one new node per level left.
// A new request is taken the cycle after a response is loaded; one request
// is in flight at a time. The walk is set by one dependent node-memory read
// per key bit, and allocation by one node-memory write per created node.
// Reset empties the trie at once (root links in flip-flops, bump pointer to
// one); the node and count memories need no clearing pass.
// A stalled receiver holds the response register; the next request is still
// accepted and worked, then waits in the controller until the register frees.
// Depends on btkc_pkg, btkc_if, btkc_ctrl and btkc_datapath.
module binary_trie_key_counter import btkc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   btkc_req_if.sink   req,
   btkc_rsp_if.source rsp
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   btkc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Memories and registers
   btkc_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req),
      .rsp   (rsp)
   );

endmodule
